[hdl/sbsr_pkg.sv]
// ----------------------------------------------------------------------------
// sbsr_pkg
// Shared types, constants and arithmetic helpers for the 3x3 stencil
// box / sobel reduction core.
// ----------------------------------------------------------------------------
package sbsr_pkg;

  // sample and pixel geometry
  localparam int SAMPLE_W  = 16;
  localparam int NUM_CH    = 9;
  localparam int PIX_W     = SAMPLE_W * NUM_CH;
  localparam int CH_W      = 4;
  localparam int FRAC_BITS = 16;

  // configuration
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 4;
  localparam int ROW_W     = 12;
  localparam logic [CFG_W-1:0] DIM_MIN      = 13'd3;
  localparam logic [CFG_W-1:0] HEIGHT_MAX   = 13'd4096;
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_t;

  // datapath widths
  localparam int BOX_W     = 20;  // sum of nine samples
  localparam int SOBEL_W   = 19;  // signed, magnitude up to 4 * 65535
  localparam int QUOT_W    = 16;  // box sum / 9
  localparam int PROD_W    = 38;  // signed sobel product
  localparam int TERM_W    = 40;  // one pixel's contribution
  localparam int SUM_W     = 63;  // accumulator / output
  localparam int DIV_IN_W  = 22;
  localparam int DIV_OUT_W = 19;

  // reciprocal of 9: exact floor for inputs below 2^22
  localparam logic [22:0] RECIP9       = 23'd7456541;
  // reciprocal of 9: exact floor for inputs up to 64
  localparam logic [13:0] SMALL_RECIP9 = 14'd228;

  // channel slots inside a pixel
  localparam logic [CH_W-1:0] CH_BOX_FIRST    = 4'd0;
  localparam logic [CH_W-1:0] CH_BOX_SECOND   = 4'd1;
  localparam logic [CH_W-1:0] CH_BOX_OFFSET   = 4'd2;
  localparam logic [CH_W-1:0] CH_HORIZ_FIRST  = 4'd3;
  localparam logic [CH_W-1:0] CH_HORIZ_SECOND = 4'd4;
  localparam logic [CH_W-1:0] CH_HORIZ_OFFSET = 4'd5;
  localparam logic [CH_W-1:0] CH_VERT_FIRST   = 4'd6;
  localparam logic [CH_W-1:0] CH_VERT_SECOND  = 4'd7;
  localparam logic [CH_W-1:0] CH_VERT_OFFSET  = 4'd8;

  // rows of a window column
  localparam logic [1:0] ROW_TOP = 2'd0;
  localparam logic [1:0] ROW_MID = 2'd1;
  localparam logic [1:0] ROW_BOT = 2'd2;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] pixel_t;
  typedef logic [2:0][NUM_CH-1:0][SAMPLE_W-1:0] column_t;

  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } stage_ctl_t;

  // 3x3 sum of one channel
  function automatic logic [BOX_W-1:0] box_sum(input column_t lf, input column_t md,
                                               input column_t rt,
                                               input logic [CH_W-1:0] ch);
    logic [BOX_W-1:0] s;
    s = '0;
    for (int r = 0; r < 3; r++) begin
      s = s + BOX_W'(lf[r][ch]) + BOX_W'(md[r][ch]) + BOX_W'(rt[r][ch]);
    end
    return s;
  endfunction

  // right column minus left column, weights 1 2 1 (two's complement)
  function automatic logic [SOBEL_W-1:0] horiz_sobel(input column_t lf, input column_t rt,
                                                     input logic [CH_W-1:0] ch);
    logic [SOBEL_W-1:0] s;
    s = SOBEL_W'(rt[ROW_TOP][ch]) - SOBEL_W'(lf[ROW_TOP][ch])
      + (SOBEL_W'(rt[ROW_MID][ch]) << 1) - (SOBEL_W'(lf[ROW_MID][ch]) << 1)
      + SOBEL_W'(rt[ROW_BOT][ch]) - SOBEL_W'(lf[ROW_BOT][ch]);
    return s;
  endfunction

  // bottom row minus top row, weights 1 2 1 (two's complement)
  function automatic logic [SOBEL_W-1:0] vert_sobel(input column_t lf, input column_t md,
                                                    input column_t rt,
                                                    input logic [CH_W-1:0] ch);
    logic [SOBEL_W-1:0] s;
    s = SOBEL_W'(lf[ROW_BOT][ch]) + (SOBEL_W'(md[ROW_BOT][ch]) << 1)
      + SOBEL_W'(rt[ROW_BOT][ch])
      - SOBEL_W'(lf[ROW_TOP][ch]) - (SOBEL_W'(md[ROW_TOP][ch]) << 1)
      - SOBEL_W'(rt[ROW_TOP][ch]);
    return s;
  endfunction

  // floor(n / 9) by reciprocal multiply
  function automatic logic [DIV_OUT_W-1:0] div9(input logic [DIV_IN_W-1:0] n);
    logic [44:0] prod;
    prod = 45'(n) * 45'(RECIP9);
    return prod[44:26];
  endfunction

  // floor(p / 9) for p up to 64
  function automatic logic [2:0] small_div9(input logic [6:0] p);
    logic [13:0] prod;
    prod = 14'(p) * SMALL_RECIP9;
    return prod[13:11];
  endfunction

endpackage

[hdl/sbsr_pixel_if.sv]
// ----------------------------------------------------------------------------
// sbsr_pixel_if
// Pixel stream channel: nine Q0.16 samples per transfer.
// ----------------------------------------------------------------------------
interface sbsr_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [sbsr_pkg::SAMPLE_W-1:0] box_first;
  logic [sbsr_pkg::SAMPLE_W-1:0] box_second;
  logic [sbsr_pkg::SAMPLE_W-1:0] box_offset;
  logic [sbsr_pkg::SAMPLE_W-1:0] horiz_first;
  logic [sbsr_pkg::SAMPLE_W-1:0] horiz_second;
  logic [sbsr_pkg::SAMPLE_W-1:0] horiz_offset;
  logic [sbsr_pkg::SAMPLE_W-1:0] vert_first;
  logic [sbsr_pkg::SAMPLE_W-1:0] vert_second;
  logic [sbsr_pkg::SAMPLE_W-1:0] vert_offset;

  modport source (
    output valid, box_first, box_second, box_offset, horiz_first, horiz_second,
           horiz_offset, vert_first, vert_second, vert_offset,
    input  ready
  );

  modport sink (
    input  valid, box_first, box_second, box_offset, horiz_first, horiz_second,
           horiz_offset, vert_first, vert_second, vert_offset,
    output ready
  );
endinterface

[hdl/sbsr_sum_if.sv]
// ----------------------------------------------------------------------------
// sbsr_sum_if
// Result channel: one signed frame total per transfer.
// ----------------------------------------------------------------------------
interface sbsr_sum_if;
  logic                              valid;
  logic                              ready;
  logic signed [sbsr_pkg::SUM_W-1:0] total_sum;

  modport source (output valid, total_sum, input ready);
  modport sink (input valid, total_sum, output ready);
endinterface

[hdl/sbsr_cfg_if.sv]
// ----------------------------------------------------------------------------
// sbsr_cfg_if
// Register write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface sbsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sbsr_pkg::CFG_IDX_W-1:0] index;
  logic [sbsr_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/stencil_box_sobel_reduce_core.sv]
// ----------------------------------------------------------------------------
// stencil_box_sobel_reduce_core
// 3x3 stencil reduction over a 9-channel raster image: box-average product,
// horizontal and vertical sobel products, summed into a saturating signed
// Q.32 frame total that is emitted with the last pixel of each frame.
// ----------------------------------------------------------------------------
//
//  channel | role | payload                              | handshake
//  --------+------+--------------------------------------+------------
//  pixel   | sink | nine 16-bit samples, raster order    | valid/ready
//  result  | src  | total_sum, 63-bit signed             | valid/ready
//  cfg     | sink | index (4 bit), data (13 bit)         | valid/ready
//
//  One pixel per cycle while pixel.ready is high. Each transfer reads both
//  line stores at the column address into registers; writeback and window
//  shift follow from stage 1, then a 6-stage arithmetic pipe feeds the
//  accumulator. The frame total is registered once the last pixel leaves it.
//  pixel.ready drops only while a total still waits on result and the next
//  frame's last pixel has reached the accumulator; cfg.ready is always high.
//  Reset is synchronous; line stores need no clearing pass, since every
//  entry is written in a frame's first two rows before it is used.
// ----------------------------------------------------------------------------
module stencil_box_sobel_reduce_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic          clk,
  input  logic          rst,
  sbsr_pixel_if.sink    pixel,
  sbsr_sum_if.source    result,
  sbsr_cfg_if.sink      cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (CW + 1 > sbsr_pkg::CFG_W) ? CW + 1 : sbsr_pkg::CFG_W;

  // configuration registers
  logic [sbsr_pkg::CFG_W-1:0] image_width;
  logic [sbsr_pkg::CFG_W-1:0] image_height;
  logic                       cfg_xfer;
  logic                       cfg_restart;
  logic [LW-1:0]              w_lim;
  logic [sbsr_pkg::CFG_W-1:0] h_lim;

  // position counters
  logic [CW-1:0]              col;
  logic [sbsr_pkg::ROW_W-1:0] row;
  logic                       last_col;
  logic                       last_row;

  // pipeline control
  logic                 adv;
  logic                 accept;
  logic                 wr_en;
  sbsr_pkg::stage_ctl_t ctl_in;
  sbsr_pkg::stage_ctl_t ctl [1:7];

  // stage 1 and line stores
  sbsr_pkg::pixel_t  pix_in;
  sbsr_pkg::pixel_t  s1_pix;
  logic [CW-1:0]     s1_col;
  sbsr_pkg::pixel_t  upper_mem [MAX_WIDTH];
  sbsr_pkg::pixel_t  middle_mem [MAX_WIDTH];
  sbsr_pkg::pixel_t  upper_rd;
  sbsr_pkg::pixel_t  middle_rd;
  sbsr_pkg::column_t cur;
  sbsr_pkg::column_t win_left;
  sbsr_pkg::column_t win_mid;

  // stage 2: window sums
  logic [sbsr_pkg::BOX_W-1:0]          s2_sa, s2_sb, s2_sc;
  logic signed [sbsr_pkg::SOBEL_W-1:0] s2_dx, s2_ex, s2_fx, s2_gy, s2_hy, s2_iy;

  // stage 3: quotients and sobel products
  logic [sbsr_pkg::DIV_OUT_W-1:0]      qa_full, qb_full, qc_full;
  logic [sbsr_pkg::QUOT_W-1:0]         s3_qa, s3_qb, s3_qc;
  logic [sbsr_pkg::BOX_W-1:0]          s3_sa, s3_sb;
  logic signed [sbsr_pkg::PROD_W-1:0]  s3_dxex, s3_gyhy;
  logic signed [sbsr_pkg::SOBEL_W:0]   s3_fi;

  // stage 4: remainder cross terms
  logic [sbsr_pkg::BOX_W-1:0]          rem_a, rem_b;
  logic [3:0]                          ra, rb;
  logic [31:0]                         s4_qq;
  logic [20:0]                         s4_x;
  logic [6:0]                          s4_p;
  logic [sbsr_pkg::QUOT_W-1:0]         s4_qc;
  logic [sbsr_pkg::PROD_W-1:0]         s4_dxex, s4_gyhy;
  logic [sbsr_pkg::SOBEL_W:0]          s4_fi;

  // stage 5
  logic [sbsr_pkg::DIV_IN_W-1:0]       s5_y;
  logic [31:0]                         s5_qq;
  logic [sbsr_pkg::QUOT_W-1:0]         s5_qc;
  logic [sbsr_pkg::TERM_W-1:0]         s5_t23;

  // stage 6
  logic [sbsr_pkg::DIV_OUT_W-1:0]      s6_yq;
  logic [32:0]                         s6_base;
  logic [sbsr_pkg::TERM_W-1:0]         s6_t23;

  // stage 7 and accumulator
  logic [sbsr_pkg::TERM_W-1:0]         s7_term;
  logic [sbsr_pkg::SUM_W-1:0]          acc;
  logic [sbsr_pkg::SUM_W:0]            acc_sum;
  logic [sbsr_pkg::SUM_W-1:0]          acc_sat;
  logic [sbsr_pkg::SUM_W-1:0]          acc_next;
  logic                                result_valid;
  logic [sbsr_pkg::SUM_W-1:0]          result_total;

  // configuration port
  assign cfg.ready   = 1'b1;
  assign cfg_xfer    = cfg.valid && cfg.ready;
  assign cfg_restart = cfg_xfer && (cfg.index == sbsr_pkg::REG_IMAGE_WIDTH ||
                                    cfg.index == sbsr_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sbsr_pkg::RESET_WIDTH;
      image_height <= sbsr_pkg::RESET_HEIGHT;
    end else if (cfg_xfer) begin
      unique case (sbsr_pkg::cfg_reg_t'(cfg.index))
        sbsr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        sbsr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // clamp frame dimensions
  always_comb begin
    priority if (LW'(image_width) < LW'(sbsr_pkg::DIM_MIN)) begin
      w_lim = LW'(sbsr_pkg::DIM_MIN);
    end else if (LW'(image_width) > LW'(MAX_WIDTH)) begin
      w_lim = LW'(MAX_WIDTH);
    end else begin
      w_lim = LW'(image_width);
    end
    priority if (image_height < sbsr_pkg::DIM_MIN) begin
      h_lim = sbsr_pkg::DIM_MIN;
    end else if (image_height > sbsr_pkg::HEIGHT_MAX) begin
      h_lim = sbsr_pkg::HEIGHT_MAX;
    end else begin
      h_lim = image_height;
    end
  end

  // handshake and stall: hold everything only when a finished total still
  // waits and the next frame end sits in front of the accumulator
  assign adv         = !(result_valid && ctl[7].valid && ctl[7].last);
  assign pixel.ready = adv;
  assign accept      = pixel.valid && pixel.ready;
  assign wr_en       = ctl[1].valid && adv;

  assign last_col = (LW'(col) + LW'(1)) >= w_lim;
  assign last_row = (sbsr_pkg::CFG_W'(row) + sbsr_pkg::CFG_W'(1)) >= h_lim;

  assign ctl_in.valid    = accept;
  assign ctl_in.interior = (row >= sbsr_pkg::ROW_W'(2)) && (col >= CW'(2));
  assign ctl_in.last     = last_col && last_row;

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + sbsr_pkg::ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // stage valid and frame flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 7; i++) begin
        ctl[i] <= '0;
      end
    end else if (adv) begin
      ctl[1] <= ctl_in;
      for (int i = 2; i <= 7; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  // gather the input samples
  always_comb begin
    pix_in = '0;
    pix_in[sbsr_pkg::CH_BOX_FIRST]    = pixel.box_first;
    pix_in[sbsr_pkg::CH_BOX_SECOND]   = pixel.box_second;
    pix_in[sbsr_pkg::CH_BOX_OFFSET]   = pixel.box_offset;
    pix_in[sbsr_pkg::CH_HORIZ_FIRST]  = pixel.horiz_first;
    pix_in[sbsr_pkg::CH_HORIZ_SECOND] = pixel.horiz_second;
    pix_in[sbsr_pkg::CH_HORIZ_OFFSET] = pixel.horiz_offset;
    pix_in[sbsr_pkg::CH_VERT_FIRST]   = pixel.vert_first;
    pix_in[sbsr_pkg::CH_VERT_SECOND]  = pixel.vert_second;
    pix_in[sbsr_pkg::CH_VERT_OFFSET]  = pixel.vert_offset;
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix <= pix_in;
      s1_col <= col;
    end
  end

  // line stores: read on transfer, written back from stage 1; the write
  // address always trails the read address by one column and an entry is
  // read again only a full row later, so no forwarding path is needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[s1_col] <= middle_rd;
    end
    if (accept) begin
      upper_rd <= upper_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      middle_mem[s1_col] <= s1_pix;
    end
    if (accept) begin
      middle_rd <= middle_mem[col];
    end
  end

  // newest window column
  always_comb begin
    cur[sbsr_pkg::ROW_TOP] = upper_rd;
    cur[sbsr_pkg::ROW_MID] = middle_rd;
    cur[sbsr_pkg::ROW_BOT] = s1_pix;
  end

  // window shift
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_left <= win_mid;
      win_mid  <= cur;
    end
  end

  // stage 2: box sums and sobel values
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sa <= sbsr_pkg::box_sum(win_left, win_mid, cur, sbsr_pkg::CH_BOX_FIRST);
      s2_sb <= sbsr_pkg::box_sum(win_left, win_mid, cur, sbsr_pkg::CH_BOX_SECOND);
      s2_sc <= sbsr_pkg::box_sum(win_left, win_mid, cur, sbsr_pkg::CH_BOX_OFFSET);
      s2_dx <= sbsr_pkg::horiz_sobel(win_left, cur, sbsr_pkg::CH_HORIZ_FIRST);
      s2_ex <= sbsr_pkg::horiz_sobel(win_left, cur, sbsr_pkg::CH_HORIZ_SECOND);
      s2_fx <= sbsr_pkg::horiz_sobel(win_left, cur, sbsr_pkg::CH_HORIZ_OFFSET);
      s2_gy <= sbsr_pkg::vert_sobel(win_left, win_mid, cur, sbsr_pkg::CH_VERT_FIRST);
      s2_hy <= sbsr_pkg::vert_sobel(win_left, win_mid, cur, sbsr_pkg::CH_VERT_SECOND);
      s2_iy <= sbsr_pkg::vert_sobel(win_left, win_mid, cur, sbsr_pkg::CH_VERT_OFFSET);
    end
  end

  // stage 3: box sums over 9, sobel products and the offset sobel sum
  always_comb begin
    qa_full = sbsr_pkg::div9(sbsr_pkg::DIV_IN_W'(s2_sa));
    qb_full = sbsr_pkg::div9(sbsr_pkg::DIV_IN_W'(s2_sb));
    qc_full = sbsr_pkg::div9(sbsr_pkg::DIV_IN_W'(s2_sc));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_qa   <= qa_full[sbsr_pkg::QUOT_W-1:0];
      s3_qb   <= qb_full[sbsr_pkg::QUOT_W-1:0];
      s3_qc   <= qc_full[sbsr_pkg::QUOT_W-1:0];
      s3_sa   <= s2_sa;
      s3_sb   <= s2_sb;
      s3_dxex <= s2_dx * s2_ex;
      s3_gyhy <= s2_gy * s2_hy;
      s3_fi   <= {s2_fx[sbsr_pkg::SOBEL_W-1], s2_fx} + {s2_iy[sbsr_pkg::SOBEL_W-1], s2_iy};
    end
  end

  // stage 4: sa*sb/81 = qa*qb + (qa*rb + qb*ra + (ra*rb)/9) / 9
  always_comb begin
    rem_a = s3_sa - (sbsr_pkg::BOX_W'(s3_qa) << 3) - sbsr_pkg::BOX_W'(s3_qa);
    rem_b = s3_sb - (sbsr_pkg::BOX_W'(s3_qb) << 3) - sbsr_pkg::BOX_W'(s3_qb);
    ra    = rem_a[3:0];
    rb    = rem_b[3:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_qq   <= 32'(s3_qa) * 32'(s3_qb);
      s4_x    <= 21'(s3_qa) * 21'(rb) + 21'(s3_qb) * 21'(ra);
      s4_p    <= 7'(ra) * 7'(rb);
      s4_qc   <= s3_qc;
      s4_dxex <= s3_dxex;
      s4_gyhy <= s3_gyhy;
      s4_fi   <= s3_fi;
    end
  end

  // stage 5: cross-term numerator, gradient terms
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_y   <= sbsr_pkg::DIV_IN_W'(s4_x) + sbsr_pkg::DIV_IN_W'(sbsr_pkg::small_div9(s4_p));
      s5_qq  <= s4_qq;
      s5_qc  <= s4_qc;
      s5_t23 <= {{(sbsr_pkg::TERM_W-sbsr_pkg::PROD_W){s4_dxex[sbsr_pkg::PROD_W-1]}}, s4_dxex}
              + {{(sbsr_pkg::TERM_W-sbsr_pkg::PROD_W){s4_gyhy[sbsr_pkg::PROD_W-1]}}, s4_gyhy}
              + ({{(sbsr_pkg::TERM_W-sbsr_pkg::SOBEL_W-1){s4_fi[sbsr_pkg::SOBEL_W]}}, s4_fi}
                 << sbsr_pkg::FRAC_BITS);
    end
  end

  // stage 6: cross term over 9, box part of the first term
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_yq   <= sbsr_pkg::div9(s5_y);
      s6_base <= 33'(s5_qq) + (33'(s5_qc) << sbsr_pkg::FRAC_BITS);
      s6_t23  <= s5_t23;
    end
  end

  // stage 7: pixel contribution
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_term <= sbsr_pkg::TERM_W'(s6_base) + sbsr_pkg::TERM_W'(s6_yq) + s6_t23;
    end
  end

  // saturating accumulate at the 63-bit signed bounds
  always_comb begin
    acc_sum = {acc[sbsr_pkg::SUM_W-1], acc}
            + {{(sbsr_pkg::SUM_W+1-sbsr_pkg::TERM_W){s7_term[sbsr_pkg::TERM_W-1]}}, s7_term};
    if (acc_sum[sbsr_pkg::SUM_W] != acc_sum[sbsr_pkg::SUM_W-1]) begin
      acc_sat = acc_sum[sbsr_pkg::SUM_W] ? {1'b1, {(sbsr_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(sbsr_pkg::SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[sbsr_pkg::SUM_W-1:0];
    end
    acc_next = ctl[7].interior ? acc_sat : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cfg_restart) begin
      acc <= '0;
    end else if (adv && ctl[7].valid) begin
      acc <= ctl[7].last ? '0 : acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result_valid <= 1'b0;
      end
      if (adv && ctl[7].valid && ctl[7].last) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl[7].valid && ctl[7].last) begin
      result_total <= acc_next;
    end
  end

  assign result.valid     = result_valid;
  assign result.total_sum = result_total;

`ifndef SYNTHESIS
  // frame end with a free result register always produces a total
  a_frame_end_emits: assert property (@(posedge clk) disable iff (rst)
    (ctl[7].valid && ctl[7].last && !result_valid) |=> result_valid)
    else $error("frame end did not load the result register");

  // a total only appears from a frame end at the accumulator
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctl[7].valid && ctl[7].last))
    else $error("result raised without a frame end");

  // column counter stays inside the clamped row width
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    LW'(col) < w_lim)
    else $error("column counter beyond row width");
`endif

endmodule
